// ===== design/fecp_pkg.sv =====
`timescale 1ns / 1ps
// Package of the foveation ellipse contour sampler: register indexes, field widths,
// reset values and the saturation helper. It depends on nothing.
package fecp_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned GridW    = 11;
  localparam int unsigned ExpW     = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RootW    = 30;
  localparam int unsigned MaxGridsDefault = 1024;

  localparam logic [GainW-1:0] GainReset = 16'd10837;
  localparam logic [GridW-1:0] GridReset = 11'd80;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFocalX    = 3'd0,
    CfgFocalY    = 3'd1,
    CfgArea      = 3'd2,
    CfgGainHoriz = 3'd3,
    CfgGainVert  = 3'd4,
    CfgGridCount = 3'd5
  } cfg_idx_e;

  // Clamp a wide signed value to the 16-bit signed coordinate range.
  function automatic logic signed [CoordW-1:0] sat16(input logic signed [47:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/foveation_ellipse_contour_points_core.sv =====
`timescale 1ns / 1ps
// Top level of the foveation ellipse contour sampler.
// Depends on fecp_pkg, fecp_sqrt_pipe and fecp_div_pipe.
//
// Each input item (ratio_exponent, grid_index) names one quality level and one
// grid position; the block returns one result item (point_x, upper_y, lower_y),
// a point pair on that level's ellipse outline. Both channels use valid and
// ready. The configuration port writes one register per cycle when cfg_we_i is
// high; the user must write it only while no item is in flight (not checked).
//
// The datapath is one long pipeline: a square root and a divider for the
// half width, a divider for the grid spacing, a multiply and square stage,
// then a second square root and divider for the half height. Every unit
// retires one bit per stage, so the pipeline is 169 register stages deep.
// The depth is set by the 42-bit spacing divider and the two 30-bit roots
// and quotients. One item is accepted per cycle while the output is not
// stalled.
//
// Reset clears all stage valid bits and loads the register defaults. When
// the receiver holds out_ready_i low with a result waiting, the whole
// pipeline freezes and in_ready_o drops; nothing is lost or repeated.
module foveation_ellipse_contour_points_core #(
  parameter int unsigned MAX_GRIDS = fecp_pkg::MaxGridsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fecp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fecp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fecp_pkg::ExpW-1:0]     ratio_exponent_i,
  input  logic [fecp_pkg::GridW-1:0]    grid_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            point_x_o,
  output logic signed [15:0]            upper_y_o,
  output logic signed [15:0]            lower_y_o
);

  localparam int unsigned RW  = fecp_pkg::RootW;
  localparam int unsigned GW  = fecp_pkg::GridW;
  localparam int unsigned GNW = fecp_pkg::GainW;
  localparam int unsigned SpanW = GW + 1 + RW;

  // Configuration registers.
  logic signed [15:0] focal_x_q, focal_y_q, area_q;
  logic [GNW-1:0]     gain_x_q, gain_y_q;
  logic [GW-1:0]      grid_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= '0;
      focal_y_q    <= '0;
      area_q       <= '0;
      gain_x_q     <= fecp_pkg::GainReset;
      gain_y_q     <= fecp_pkg::GainReset;
      grid_count_q <= fecp_pkg::GridReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fecp_pkg::CfgFocalX:    focal_x_q    <= cfg_data_i;
        fecp_pkg::CfgFocalY:    focal_y_q    <= cfg_data_i;
        fecp_pkg::CfgArea:      area_q       <= cfg_data_i;
        fecp_pkg::CfgGainHoriz: gain_x_q     <= cfg_data_i;
        fecp_pkg::CfgGainVert:  gain_y_q     <= cfg_data_i;
        fecp_pkg::CfgGridCount: grid_count_q <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // Effective operands: a zero gain acts as one LSB, the grid count is capped.
  logic [GNW-1:0] gain_x_eff, gain_y_eff;
  logic [GW-1:0]  grid_n;
  logic           grid_zero;
  logic [GW-1:0]  grid_den;

  assign gain_x_eff = (gain_x_q == '0) ? GNW'(1) : gain_x_q;
  assign gain_y_eff = (gain_y_q == '0) ? GNW'(1) : gain_y_q;
  assign grid_n     = (32'(grid_count_q) > MAX_GRIDS) ? GW'(MAX_GRIDS) : grid_count_q;
  assign grid_zero  = (grid_n == '0);
  assign grid_den   = grid_zero ? GW'(1) : grid_n;

  // The whole pipeline moves together whenever the output slot is free.
  logic en;
  logic out_vld_q;
  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;

  // Stage A: level radicand R = 2^k * 256 + area, clamped at zero.
  logic               a_vld_q;
  logic [15:0]        a_rad_q;
  logic [GW-1:0]      a_idx_q;
  logic [16:0]        lvl;
  logic signed [17:0] rs;

  assign lvl = 17'd256 << ratio_exponent_i;
  assign rs  = $signed({1'b0, lvl}) + 18'(area_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_rad_q <= rs[17] ? 16'd0 : rs[15:0];
      a_idx_q <= grid_index_i;
    end
  end

  // Half width: sqrt(R * 2^44) / gain_x.
  logic          s1_vld;
  logic [RW-1:0] s1_root;
  logic [15+GW:0] s1_side;

  fecp_sqrt_pipe #(.RW(RW), .SW(16 + GW)) u_sqrt_w (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(a_vld_q), .radicand_i({a_rad_q, 44'd0}), .side_i({a_rad_q, a_idx_q}),
    .valid_o(s1_vld), .root_o(s1_root), .side_o(s1_side)
  );

  logic           d1_vld;
  logic [RW-1:0]  d1_wq;
  logic [15+GW:0] d1_side;

  fecp_div_pipe #(.NW(RW), .DW(GNW), .SW(16 + GW)) u_div_w (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s1_vld), .num_i(s1_root), .den_i(gain_x_eff), .side_i(s1_side),
    .valid_o(d1_vld), .quot_o(d1_wq), .side_o(d1_side)
  );

  // Stage B: spacing numerator i * 2 * w.
  logic             b_vld_q;
  logic [SpanW-1:0] b_prod_q;
  logic [RW-1:0]    b_wq_q;
  logic [15:0]      b_rad_q;
  logic             b_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_prod_q <= SpanW'({d1_side[GW-1:0], 1'b0}) * SpanW'(d1_wq);
      b_wq_q   <= d1_wq;
      b_rad_q  <= d1_side[15+GW:GW];
      b_zero_q <= grid_zero;
    end
  end

  logic             d2_vld;
  logic [SpanW-1:0] d2_span;
  logic [RW+16:0]   d2_side;

  fecp_div_pipe #(.NW(SpanW), .DW(GW), .SW(RW + 17)) u_div_span (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(b_vld_q), .num_i(b_prod_q), .den_i(grid_den),
    .side_i({b_wq_q, b_rad_q, b_zero_q}),
    .valid_o(d2_vld), .quot_o(d2_span), .side_o(d2_side)
  );

  // Stage C: sample x, saturated, and its distance from the centre.
  logic               c_vld_q;
  logic signed [15:0] c_px_q;
  logic [15:0]        c_ad_q;
  logic [15:0]        c_rad_q;
  logic signed [47:0] xq;
  logic signed [15:0] px;
  logic signed [16:0] dx;

  assign xq = 48'(focal_x_q) - $signed({18'd0, d2_side[RW+16:17]})
            + (d2_side[0] ? 48'sd0 : $signed({6'd0, d2_span}));
  assign px = fecp_pkg::sat16(xq);
  assign dx = 17'(px) - 17'(focal_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_px_q  <= px;
      c_ad_q  <= dx[16] ? 16'(-dx) : dx[15:0];
      c_rad_q <= d2_side[16:1];
    end
  end

  // Stage D: p = |d| * gain_x.
  logic               dd_vld_q;
  logic [31:0]        dd_p_q;
  logic signed [15:0] dd_px_q;
  logic [15:0]        dd_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dd_vld_q <= 1'b0;
    end else if (en) begin
      dd_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_p_q   <= c_ad_q * gain_x_eff;
      dd_px_q  <= c_px_q;
      dd_rad_q <= c_rad_q;
    end
  end

  // Stage E: p squared; a p of 2^30 or more forces the leftover to zero.
  logic               e_vld_q;
  logic [59:0]        e_sq_q;
  logic               e_big_q;
  logic signed [15:0] e_px_q;
  logic [15:0]        e_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= dd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_sq_q  <= dd_p_q[29:0] * dd_p_q[29:0];
      e_big_q <= |dd_p_q[31:30];
      e_px_q  <= dd_px_q;
      e_rad_q <= dd_rad_q;
    end
  end

  // Stage F: leftover t = R * 2^44 - p^2, clamped at zero.
  logic               f_vld_q;
  logic [59:0]        f_t_q;
  logic signed [15:0] f_px_q;
  logic [59:0]        r44;

  assign r44 = {e_rad_q, 44'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_t_q  <= (!e_big_q && (r44 > e_sq_q)) ? (r44 - e_sq_q) : 60'd0;
      f_px_q <= e_px_q;
    end
  end

  // Half height: sqrt(t) / gain_y.
  logic          s2_vld;
  logic [RW-1:0] s2_root;
  logic [15:0]   s2_side;

  fecp_sqrt_pipe #(.RW(RW), .SW(16)) u_sqrt_h (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_vld_q), .radicand_i(f_t_q), .side_i(f_px_q),
    .valid_o(s2_vld), .root_o(s2_root), .side_o(s2_side)
  );

  logic          d3_vld;
  logic [RW-1:0] d3_hq;
  logic [15:0]   d3_side;

  fecp_div_pipe #(.NW(RW), .DW(GNW), .SW(16)) u_div_h (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s2_vld), .num_i(s2_root), .den_i(gain_y_eff), .side_i(s2_side),
    .valid_o(d3_vld), .quot_o(d3_hq), .side_o(d3_side)
  );

  // Stage G: output register with the two saturated y values.
  logic signed [47:0] hq_ext;
  assign hq_ext = $signed({18'd0, d3_hq});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      point_x_o <= d3_side;
      upper_y_o <= fecp_pkg::sat16(48'(focal_y_q) + hq_ext);
      lower_y_o <= fecp_pkg::sat16(48'(focal_y_q) - hq_ext);
    end
  end

endmodule

// ===== design/fecp_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per register stage.
// Uses fecp_pkg for its default width.
module fecp_sqrt_pipe #(
  parameter int unsigned RW = fecp_pkg::RootW,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] radicand_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SW-1:0]   side_q [RW];
  logic [RW-1:0]   vld_q;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+1:0]   pr;
    logic [RW-1:0]   proot;
    logic [2*RW-1:0] prad;
    logic [SW-1:0]   pside;
    logic            pv;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    if (j == 0) begin : g_first
      assign pr    = '0;
      assign proot = '0;
      assign prad  = radicand_i;
      assign pside = side_i;
      assign pv    = valid_i;
    end else begin : g_next
      assign pr    = rem_q[j-1];
      assign proot = root_q[j-1];
      assign prad  = rad_q[j-1];
      assign pside = side_q[j-1];
      assign pv    = vld_q[j-1];
    end

    assign rem_sh = {pr, prad[2*RW-1 -: 2]};
    assign trial  = {2'b00, proot, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_q[j] <= {proot[RW-2:0], ge};
        rad_q[j]  <= {prad[2*RW-3:0], 2'b00};
        side_q[j] <= pside;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== design/fecp_div_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Uses fecp_pkg for its default widths.
module fecp_div_pipe #(
  parameter int unsigned NW = fecp_pkg::RootW,
  parameter int unsigned DW = fecp_pkg::GainW,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] quot_q [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic [NW-1:0] vld_q;

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [DW-1:0] pr;
    logic [NW-1:0] pq;
    logic [NW-1:0] pn;
    logic [DW-1:0] pd;
    logic [SW-1:0] pside;
    logic          pv;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign pr    = '0;
      assign pq    = '0;
      assign pn    = num_i;
      assign pd    = den_i;
      assign pside = side_i;
      assign pv    = valid_i;
    end else begin : g_next
      assign pr    = rem_q[j-1];
      assign pq    = quot_q[j-1];
      assign pn    = num_q[j-1];
      assign pd    = den_q[j-1];
      assign pside = side_q[j-1];
      assign pv    = vld_q[j-1];
    end

    assign rem_sh = {pr, pn[NW-1]};
    assign ge     = rem_sh >= {1'b0, pd};
    assign diff   = rem_sh - {1'b0, pd};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        quot_q[j] <= {pq[NW-2:0], ge};
        num_q[j]  <= {pn[NW-2:0], 1'b0};
        den_q[j]  <= pd;
        side_q[j] <= pside;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = quot_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule
